/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/jfs_pkg.sv */
package jfs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int JOB_ID_BITS = 8;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;
  localparam int REL_W  = 6;
  localparam int BLK_W  = 6;
  localparam int OUTST_W = 16;
  localparam int FENCE_W = 6;

  localparam logic [CMD_W-1:0] CMD_SUBMIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FENCE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN      = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    logic                   fence;
    logic [JOB_ID_BITS-1:0] id;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } fifo_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    entry_t           head_entry;
  } fifo_sts_t;

endpackage

/* hdl/jfs_req_if.sv */
interface jfs_req_if;
  logic                            valid;
  logic                            ready;
  logic [jfs_pkg::CMD_W-1:0]       command;
  logic [jfs_pkg::JOB_ID_BITS-1:0] job_id;
  logic                            job_is_fence;
  logic                            dispatch_queue_empty;

  modport source (output valid, command, job_id, job_is_fence, dispatch_queue_empty,
                  input ready);
  modport sink (input valid, command, job_id, job_is_fence, dispatch_queue_empty,
                output ready);
endinterface

/* hdl/jfs_rsp_if.sv */
interface jfs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [jfs_pkg::KIND_W-1:0]      kind;
  logic [jfs_pkg::JOB_ID_BITS-1:0] out_job_id;
  logic                            to_front;
  logic [jfs_pkg::REL_W-1:0]       released_count;
  logic                            fence_raised;
  logic [jfs_pkg::BLK_W-1:0]       blocked_count;
  logic                            last;

  modport source (output valid, kind, out_job_id, to_front, released_count, fence_raised,
                  blocked_count, last, input ready);
  modport sink (input valid, kind, out_job_id, to_front, released_count, fence_raised,
                blocked_count, last, output ready);
endinterface

/* hdl/job_fence_scheduler.sv */
// Fence scheduler for jobs. Each request transaction carries a submit, a fence
// raise or a completion; each gives one or more response transactions, the
// final one marked by last. Submits and fence raises are accepted, then in
// S_EXEC run the job, queue it in the blocked FIFO, or report an overflow if
// it is full. A completion updates the counters in S_EXEC and ends with the
// done response from S_DONE. A walk of the blocked FIFO visits S_CHK and
// S_WAIT for each job released ahead of its last step and ends in S_CHK with
// a step that releases a fence, releases the head job to the front, or stops;
// the FIFO head is read from a memory with a registered read port and each
// release waits in S_WAIT for the next head entry. The request side stays busy
// until the final response is in the output register; a response that is not
// taken stalls the sequencer. The blocked FIFO needs no clearing after reset.
`include "assert_macros.svh"

module job_fence_scheduler (
  input logic clk,
  input logic rst,
  jfs_req_if.sink   req,
  jfs_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHK,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state, state_next;

  logic [jfs_pkg::CMD_W-1:0]       cmd;
  logic [jfs_pkg::JOB_ID_BITS-1:0] job_id;
  logic                            job_is_fence;
  logic                            dq_empty;

  logic                            front_mode, front_mode_next;
  logic [jfs_pkg::REL_W-1:0]       rel, rel_next;
  logic [jfs_pkg::OUTST_W-1:0]     outstanding, outstanding_next;
  logic [jfs_pkg::FENCE_W-1:0]     fence_count, fence_count_next;

  jfs_pkg::fifo_ctl_t fifo_ctl;
  jfs_pkg::fifo_sts_t fifo_sts;

  logic                            out_free;
  logic                            emit;
  jfs_pkg::kind_t                  e_kind;
  logic [jfs_pkg::JOB_ID_BITS-1:0] e_id;
  logic                            e_front;
  logic [jfs_pkg::REL_W-1:0]       e_rel;
  logic                            e_fence;
  logic [jfs_pkg::CNT_W-1:0]       e_blocked;
  logic                            e_last;

  jfs_fifo u_fifo (
    .clk (clk),
    .rst (rst),
    .ctl (fifo_ctl),
    .sts (fifo_sts)
  );

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    front_mode_next  = front_mode;
    rel_next         = rel;
    outstanding_next = outstanding;
    fence_count_next = fence_count;
    fifo_ctl.push    = 1'b0;
    fifo_ctl.pop     = 1'b0;
    fifo_ctl.wdata   = '{fence: cmd == jfs_pkg::CMD_FENCE, id: job_id};
    emit             = 1'b0;
    e_kind           = jfs_pkg::KIND_DONE;
    e_id             = '0;
    e_front          = 1'b0;
    e_rel            = '0;
    e_fence          = (fence_count != '0);
    e_blocked        = fifo_sts.count;
    e_last           = 1'b0;

    case (state)
      S_IDLE: begin
        rel_next = '0;
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd)
          jfs_pkg::CMD_SUBMIT, jfs_pkg::CMD_FENCE: begin
            if (out_free) begin
              emit       = 1'b1;
              e_id       = job_id;
              e_last     = 1'b1;
              state_next = S_IDLE;
              if (fence_count == '0 && (cmd == jfs_pkg::CMD_SUBMIT || outstanding == '0)) begin
                e_kind = jfs_pkg::KIND_RUN;
                if (outstanding != '1) begin
                  outstanding_next = outstanding + 1'b1;
                end
                if (cmd == jfs_pkg::CMD_FENCE) begin
                  fence_count_next = jfs_pkg::FENCE_W'(1);
                  e_fence          = 1'b1;
                end
              end else if (!fifo_sts.full) begin
                e_kind        = jfs_pkg::KIND_BLOCKED;
                fifo_ctl.push = 1'b1;
                e_blocked     = fifo_sts.count + 1'b1;
                if (cmd == jfs_pkg::CMD_FENCE) begin
                  e_fence = 1'b1;
                  if (fence_count != '1) begin
                    fence_count_next = fence_count + 1'b1;
                  end
                end
              end else begin
                e_kind = jfs_pkg::KIND_OVERFLOW;
              end
            end
          end

          jfs_pkg::CMD_COMPLETE: begin
            if (outstanding != '0) begin
              outstanding_next = outstanding - 1'b1;
            end
            front_mode_next = 1'b0;
            state_next      = S_DONE;
            if (job_is_fence) begin
              if (fence_count != '0) begin
                fence_count_next = fence_count - 1'b1;
              end
              if (fifo_sts.count != '0) begin
                state_next = S_CHK;
              end
            end else if (outstanding_next == '0 && fence_count != '0 &&
                         fifo_sts.count != '0) begin
              front_mode_next = 1'b1;
              state_next      = S_CHK;
            end
          end

          default: begin
            // Unused command: drop it.
            state_next = S_IDLE;
          end
        endcase
      end

      S_CHK: begin
        if (fifo_sts.count == '0) begin
          state_next = S_DONE;
        end else if (fifo_sts.head_entry.fence && !front_mode &&
                     !(outstanding == '0 && dq_empty)) begin
          // Hold the fence at the head.
          state_next = S_DONE;
        end else if (out_free) begin
          emit         = 1'b1;
          e_kind       = jfs_pkg::KIND_RELEASED;
          e_id         = fifo_sts.head_entry.id;
          e_front      = front_mode;
          e_blocked    = fifo_sts.count - 1'b1;
          fifo_ctl.pop = 1'b1;
          rel_next     = rel + 1'b1;
          if (outstanding != '1) begin
            outstanding_next = outstanding + 1'b1;
          end
          if (front_mode || fifo_sts.head_entry.fence) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        // Let the registered head read catch up after the pop.
        state_next = S_CHK;
      end

      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = jfs_pkg::KIND_DONE;
          e_rel      = rel;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_mode  <= 1'b0;
      rel         <= '0;
      outstanding <= '0;
      fence_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_mode  <= front_mode_next;
      rel         <= rel_next;
      outstanding <= outstanding_next;
      fence_count <= fence_count_next;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (req.valid && req.ready) begin
      cmd          <= req.command;
      job_id       <= req.job_id;
      job_is_fence <= req.job_is_fence;
      dq_empty     <= req.dispatch_queue_empty;
    end
    if (emit) begin
      rsp.kind           <= e_kind;
      rsp.out_job_id     <= e_id;
      rsp.to_front       <= e_front;
      rsp.released_count <= e_rel;
      rsp.fence_raised   <= e_fence;
      rsp.blocked_count  <= jfs_pkg::BLK_W'(e_blocked);
      rsp.last           <= e_last;
    end
  end

  `ASSERT_NOW(a_no_push_pop, fifo_ctl.push, !fifo_ctl.pop)
  `ASSERT_NOW(a_pop_nonempty, fifo_ctl.pop, fifo_sts.count != '0)
  `ASSERT_NOW(a_push_not_full, fifo_ctl.push, !fifo_sts.full)
  `ASSERT_NEXT(a_accept_exec, req.valid && req.ready, state == S_EXEC)
  `ASSERT_NOW(a_emit_slot_free, emit, !rsp.valid || rsp.ready)

endmodule

/* hdl/jfs_fifo.sv */
module jfs_fifo (
  input  logic               clk,
  input  logic               rst,
  input  jfs_pkg::fifo_ctl_t ctl,
  output jfs_pkg::fifo_sts_t sts
);

  jfs_pkg::entry_t mem [jfs_pkg::QUEUE_DEPTH];

  logic [jfs_pkg::ADDR_W-1:0] head;
  logic [jfs_pkg::CNT_W-1:0]  count;
  logic [jfs_pkg::ADDR_W-1:0] tail;
  logic [jfs_pkg::CNT_W:0]    tail_sum;
  jfs_pkg::entry_t            rd_data;

  // Tail is head plus fill level, wrapped once.
  always_comb begin
    tail_sum = (jfs_pkg::CNT_W+1)'(head) + (jfs_pkg::CNT_W+1)'(count);
    if (tail_sum >= (jfs_pkg::CNT_W+1)'(jfs_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (jfs_pkg::CNT_W+1)'(jfs_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[jfs_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.wdata;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        count <= count - 1'b1;
        if (head == jfs_pkg::ADDR_W'(jfs_pkg::QUEUE_DEPTH - 1)) begin
          head <= '0;
        end else begin
          head <= head + 1'b1;
        end
      end
    end
  end

  assign sts.count      = count;
  assign sts.full       = (count == jfs_pkg::CNT_W'(jfs_pkg::QUEUE_DEPTH));
  assign sts.head_entry = rd_data;

endmodule
